FILE: rtl/core/axis_angle_point_rotation_unit_macros.svh
// ----------------------------------------------------------------------------
// axis angle point rotation unit assertion macros
// shared property forms for the rotation unit checks
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_POINT_ROTATION_UNIT_MACROS_SVH
`define AXIS_ANGLE_POINT_ROTATION_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define AAPR_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rotation unit check failed");

// next-cycle implication, clocked on clk, quiet during reset
`define AAPR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rotation unit check failed");

`endif

FILE: rtl/core/aapr_pkg.sv
// ----------------------------------------------------------------------------
// aapr_pkg
// constants and tables of the axis angle point rotation unit
// ----------------------------------------------------------------------------
`default_nettype none

package aapr_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	// fixed point layout
	localparam int UNIT_FRAC    = 30;
	localparam int ROOT_BITS    = 31;
	localparam int QUO_BITS     = 31;
	localparam int CORDIC_STEPS = 30;
	localparam int XW           = 34;

	localparam logic signed [31:0] PI_Q29       = 32'sd1686629713;
	localparam logic signed [31:0] HALF_PI_Q29  = 32'sd843314856;
	localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;
	localparam logic signed [31:0] HALF_Q30     = 32'sd536870912;
	localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;

	// arctan(2^-i) in Q2.30
	localparam logic [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

endpackage

`default_nettype wire

FILE: rtl/core/axis_angle_point_rotation_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_point_rotation_unit
// rotates a Q16.16 point about an axis through the origin (Rodrigues matrix)
// ----------------------------------------------------------------------------
// The unit takes one word per cycle unless stalled and returns one rotated
// point per word, in order. The pipeline length is set by the two bit-per-
// stage chains in the middle: a 31-stage integer square root of the axis
// length followed by a register that forms the rounded numerators and 31
// stages of three parallel restoring dividers, with the 30-step CORDIC for
// cos and sin running alongside the dividers. Five stages before them
// normalize the axis and fold the angle, eight after them build the matrix
// and multiply by the point. The whole pipeline advances together: when the
// output word is stalled every stage holds, and bubbles travel as invalid
// stages. A zero axis yields cos times the point and sets zero_axis_flag;
// clamped components set saturated_flag.
`default_nettype none

module axis_angle_point_rotation_unit
	import aapr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [31:0]            turn_angle,
	input  logic signed [COORD_WIDTH-1:0] axis_x,
	input  logic signed [COORD_WIDTH-1:0] axis_y,
	input  logic signed [COORD_WIDTH-1:0] axis_z,
	output logic                          rotated_valid,
	input  logic                          rotated_stall,
	output logic signed [COORD_WIDTH-1:0] rotated_x,
	output logic signed [COORD_WIDTH-1:0] rotated_y,
	output logic signed [COORD_WIDTH-1:0] rotated_z,
	output logic                          saturated_flag,
	output logic                          zero_axis_flag
);

	`include "axis_angle_point_rotation_unit_macros.svh"

	localparam int CW   = COORD_WIDTH;
	localparam int LW   = $clog2(CW + 1);
	localparam int MW   = (CW > UNIT_FRAC) ? CW : UNIT_FRAC;
	localparam int HI_W = (CW > 32) ? CW - 32 : 1;
	localparam int HSW  = 34 + HI_W;
	localparam int TW   = 67 + HI_W;
	localparam int RW   = TW - 30;

	localparam logic [QUO_BITS-1:0] QUO_MAX = QUO_BITS'(1) << UNIT_FRAC;
	localparam logic signed [XW:0]  ONE_W   = (XW + 1)'(ONE_Q30);

	typedef struct packed {
		logic [32:0]          rem;
		logic [30:0]          root;
		logic [61:0]          rad;
		logic [2:0][29:0]     nm;
		logic [2:0]           neg;
		logic [2:0][CW-1:0]   p;
		logic                 zero;
		logic signed [XW-1:0] z;
		logic                 flip;
	} sq_t;

	typedef struct packed {
		logic [2:0][60:0]          num;
		logic [30:0]               den;
		logic [2:0][QUO_BITS-1:0]  quo;
		logic [2:0]                neg;
		logic [2:0][CW-1:0]        p;
		logic                      zero;
		logic signed [XW-1:0]      x;
		logic signed [XW-1:0]      y;
		logic signed [XW-1:0]      z;
		logic                      flip;
	} dv_t;

	function automatic logic signed [XW-1:0] mulq(input logic signed [XW-1:0] a,
			input logic signed [31:0] b);
		logic signed [XW+31:0] pr;
		pr = a * b;
		pr = pr + (XW + 32)'(HALF_Q30);
		return XW'(pr >>> UNIT_FRAC);
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [XW:0] v);
		if (v > ONE_W)
			return ONE_Q30;
		if (v < -ONE_W)
			return -ONE_Q30;
		return 32'(v);
	endfunction

	logic adv;
	logic v_s13;

	assign adv         = !(v_s13 && rotated_stall);
	assign point_stall = !adv;

	logic signed [CW-1:0] point_in [3];
	logic signed [CW-1:0] axis_in  [3];

	assign point_in[0] = point_x;
	assign point_in[1] = point_y;
	assign point_in[2] = point_z;
	assign axis_in[0]  = axis_x;
	assign axis_in[1]  = axis_y;
	assign axis_in[2]  = axis_z;

	// front stages: magnitudes, angle fold, axis normalize, squares
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [CW-1:0] p_s1 [3], p_s2 [3], p_s3 [3], p_s4 [3], p_s5 [3];
	logic [CW-1:0] mag_s1 [3], mag_s2 [3];
	logic [2:0] neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic signed [31:0] ang_s1;
	logic signed [XW-1:0] z_s2, z_s3, z_s4, z_s5;
	logic flip_s2, flip_s3, flip_s4, flip_s5;
	logic [LW-1:0] len_s2;
	logic [29:0] nm_s3 [3], nm_s4 [3], nm_s5 [3];
	logic [59:0] sq_s4 [3];
	logic [61:0] s_s5;

	logic [CW-1:0] mag_d [3];
	logic signed [31:0] ang_d;
	logic [CW-1:0] orv;
	logic [LW-1:0] len_d;
	logic signed [32:0] fold_d;
	logic flip_d;
	logic [LW:0] rs_d, ls_d;
	logic [MW-1:0] mext_d [3], shr_d [3], shl_d [3];
	logic [29:0] nm_d [3];

	always_comb begin
		for (int j = 0; j < 3; j++)
			mag_d[j] = axis_in[j][CW-1] ? CW'(-axis_in[j]) : CW'(axis_in[j]);
		if (turn_angle > PI_Q29)
			ang_d = PI_Q29;
		else if (turn_angle < -PI_Q29)
			ang_d = -PI_Q29;
		else
			ang_d = turn_angle;
	end

	always_comb begin
		orv   = mag_s1[0] | mag_s1[1] | mag_s1[2];
		len_d = '0;
		for (int i = 0; i < CW; i++)
			if (orv[i])
				len_d = LW'(i + 1);
		// fold to within half pi, the results get negated later
		flip_d = 1'b1;
		if (ang_s1 > HALF_PI_Q29)
			fold_d = 33'(ang_s1) - 33'(PI_Q29);
		else if (ang_s1 < -HALF_PI_Q29)
			fold_d = 33'(ang_s1) + 33'(PI_Q29);
		else begin
			fold_d = 33'(ang_s1);
			flip_d = 1'b0;
		end
	end

	always_comb begin
		rs_d = {1'b0, len_s2} - (LW + 1)'(UNIT_FRAC);
		ls_d = (LW + 1)'(UNIT_FRAC) - {1'b0, len_s2};
		for (int j = 0; j < 3; j++) begin
			mext_d[j] = MW'(mag_s2[j]);
			shr_d[j]  = mext_d[j] >> rs_d;
			shl_d[j]  = mext_d[j] << ls_d;
			nm_d[j]   = (len_s2 > LW'(UNIT_FRAC)) ? shr_d[j][29:0] : shl_d[j][29:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				p_s1[j]   <= point_in[j];
				mag_s1[j] <= mag_d[j];
				neg_s1[j] <= axis_in[j][CW-1];
				p_s2[j]   <= p_s1[j];
				mag_s2[j] <= mag_s1[j];
				p_s3[j]   <= p_s2[j];
				nm_s3[j]  <= nm_d[j];
				p_s4[j]   <= p_s3[j];
				nm_s4[j]  <= nm_s3[j];
				sq_s4[j]  <= nm_s3[j] * nm_s3[j];
				p_s5[j]   <= p_s4[j];
				nm_s5[j]  <= nm_s4[j];
			end
			zero_s1 <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
			ang_s1  <= ang_d;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			len_s2  <= len_d;
			z_s2    <= {fold_d, 1'b0};
			flip_s2 <= flip_d;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			z_s3    <= z_s2;
			flip_s3 <= flip_s2;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			z_s4    <= z_s3;
			flip_s4 <= flip_s3;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			z_s5    <= z_s4;
			flip_s5 <= flip_s4;
			s_s5    <= 62'(sq_s4[0]) + 62'(sq_s4[1]) + 62'(sq_s4[2]);
		end
	end

	// square root, one root bit per stage
	sq_t  sqrt_s [ROOT_BITS];
	logic sqrt_v [ROOT_BITS];
	sq_t  sq_head;

	always_comb begin
		sq_head      = '0;
		sq_head.rad  = s_s5;
		sq_head.neg  = neg_s5;
		sq_head.zero = zero_s5;
		sq_head.z    = z_s5;
		sq_head.flip = flip_s5;
		for (int j = 0; j < 3; j++) begin
			sq_head.nm[j] = nm_s5[j];
			sq_head.p[j]  = p_s5[j];
		end
	end

	for (genvar gi = 0; gi < ROOT_BITS; gi++) begin : g_sqrt
		sq_t cur, nxt;
		logic cur_v;
		logic [34:0] acc;
		logic [32:0] trial;

		if (gi == 0) begin : g_src
			assign cur   = sq_head;
			assign cur_v = v_s5;
		end else begin : g_src
			assign cur   = sqrt_s[gi-1];
			assign cur_v = sqrt_v[gi-1];
		end

		always_comb begin
			nxt     = cur;
			acc     = {cur.rem, cur.rad[61:60]};
			trial   = {cur.root, 2'b01};
			nxt.rad = {cur.rad[59:0], 2'b00};
			if (acc >= {2'b00, trial}) begin
				nxt.rem  = 33'(acc - {2'b00, trial});
				nxt.root = {cur.root[29:0], 1'b1};
			end else begin
				nxt.rem  = acc[32:0];
				nxt.root = {cur.root[29:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				sqrt_s[gi] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqrt_v[gi] <= 1'b0;
			else if (adv)
				sqrt_v[gi] <= cur_v;
		end
	end

	// dividers for the unit axis, cordic iterations alongside
	dv_t  div_s [QUO_BITS+1];
	logic div_v [QUO_BITS+1];
	dv_t  dv_head;

	always_comb begin
		dv_head      = '0;
		dv_head.den  = sqrt_s[ROOT_BITS-1].root;
		dv_head.neg  = sqrt_s[ROOT_BITS-1].neg;
		dv_head.p    = sqrt_s[ROOT_BITS-1].p;
		dv_head.zero = sqrt_s[ROOT_BITS-1].zero;
		dv_head.x    = XW'(GAIN_INV_Q30);
		dv_head.z    = sqrt_s[ROOT_BITS-1].z;
		dv_head.flip = sqrt_s[ROOT_BITS-1].flip;
		// round half up: numerator gets half the divisor
		for (int j = 0; j < 3; j++)
			dv_head.num[j] = {1'b0, sqrt_s[ROOT_BITS-1].nm[j], 30'b0}
				+ 61'(sqrt_s[ROOT_BITS-1].root[30:1]);
	end

	always_ff @(posedge clk) begin
		if (adv)
			div_s[0] <= dv_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_v[0] <= 1'b0;
		else if (adv)
			div_v[0] <= sqrt_v[ROOT_BITS-1];
	end

	for (genvar gk = 1; gk <= QUO_BITS; gk++) begin : g_div
		localparam int B  = QUO_BITS - gk;
		localparam int CI = gk - 1;
		dv_t cur, nxt;
		logic [60:0] trial;
		logic signed [XW-1:0] cx, cy, cz;

		assign cur   = div_s[gk-1];
		assign trial = 61'(cur.den) << B;

		if (CI < CORDIC_STEPS) begin : g_rot
			logic signed [XW-1:0] dx, dy, at;
			assign dx = cur.y >>> CI;
			assign dy = cur.x >>> CI;
			assign at = XW'(ATAN_Q30[CI]);
			assign cx = cur.z[XW-1] ? cur.x + dx : cur.x - dx;
			assign cy = cur.z[XW-1] ? cur.y - dy : cur.y + dy;
			assign cz = cur.z[XW-1] ? cur.z + at : cur.z - at;
		end else begin : g_rot
			assign cx = cur.x;
			assign cy = cur.y;
			assign cz = cur.z;
		end

		always_comb begin
			nxt   = cur;
			nxt.x = cx;
			nxt.y = cy;
			nxt.z = cz;
			for (int j = 0; j < 3; j++) begin
				if (cur.num[j] >= trial) begin
					nxt.num[j]    = cur.num[j] - trial;
					nxt.quo[j][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				div_s[gk] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v[gk] <= 1'b0;
			else if (adv)
				div_v[gk] <= div_v[gk-1];
		end
	end

	// back stages: matrix and point product
	logic v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic zero_s6, zero_s7, zero_s8, zero_s9, zero_s10, zero_s11, zero_s12, zero_s13;
	logic signed [CW-1:0] p_s6 [3], p_s7 [3], p_s8 [3], p_s9 [3];
	logic signed [31:0] u_s6 [3], u_s7 [3];
	logic signed [XW-1:0] c_s6, s_s6, t_s6, c_s7, c_s8;
	logic signed [XW-1:0] tx_s7 [3], sx_s7 [3], sx_s8 [3];
	logic signed [XW-1:0] txx_s8, tyy_s8, tzz_s8, txy_s8, txz_s8, tyz_s8;
	logic signed [31:0] m_s9 [3][3];
	logic signed [64:0] plo_s10 [3][3];
	logic signed [31+HI_W:0] phi_s10 [3][3];
	logic signed [66:0] lo_s11 [3];
	logic signed [HSW-1:0] hi_s11 [3];
	logic signed [RW-1:0] r_s12 [3];
	logic signed [CW-1:0] rot_s13 [3];
	logic sat_s13;

	logic signed [31:0] u_d [3];
	logic [31:0] qx_d [3];
	logic signed [XW-1:0] c_d, s_d;
	logic signed [CW+31:0] pext_d [3];
	logic [31:0] plo_d [3];
	logic signed [HI_W-1:0] phi_d [3];
	logic signed [TW-1:0] tot_d [3];
	logic signed [CW-1:0] rot_d [3];
	logic [2:0] ovf_d;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qx_d[j] = {1'b0, div_s[QUO_BITS].quo[j]};
			if (div_s[QUO_BITS].zero)
				u_d[j] = '0;
			else if (div_s[QUO_BITS].neg[j])
				u_d[j] = $signed(32'd0 - qx_d[j]);
			else
				u_d[j] = $signed(qx_d[j]);
		end
		c_d = div_s[QUO_BITS].flip ? -div_s[QUO_BITS].x : div_s[QUO_BITS].x;
		s_d = div_s[QUO_BITS].flip ? -div_s[QUO_BITS].y : div_s[QUO_BITS].y;
	end

	// point split into a signed high part and an unsigned low word
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pext_d[k] = (CW + 32)'(p_s9[k]);
			plo_d[k]  = pext_d[k][31:0];
			phi_d[k]  = $signed(pext_d[k][31+HI_W:32]);
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			tot_d[j] = (TW'(hi_s11[j]) <<< 32) + TW'(lo_s11[j]);
			ovf_d[j] = !((&r_s12[j][RW-1:CW-1]) || (~|r_s12[j][RW-1:CW-1]));
			if (ovf_d[j])
				rot_d[j] = r_s12[j][RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			else
				rot_d[j] = r_s12[j][CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				u_s6[j]  <= u_d[j];
				p_s6[j]  <= $signed(div_s[QUO_BITS].p[j]);
				u_s7[j]  <= u_s6[j];
				p_s7[j]  <= p_s6[j];
				tx_s7[j] <= mulq(t_s6, u_s6[j]);
				sx_s7[j] <= mulq(s_s6, u_s6[j]);
				sx_s8[j] <= sx_s7[j];
				p_s8[j]  <= p_s7[j];
				p_s9[j]  <= p_s8[j];
				for (int k = 0; k < 3; k++) begin
					plo_s10[j][k] <= m_s9[j][k] * $signed({1'b0, plo_d[k]});
					phi_s10[j][k] <= m_s9[j][k] * phi_d[k];
				end
				lo_s11[j]  <= 67'(plo_s10[j][0]) + 67'(plo_s10[j][1]) + 67'(plo_s10[j][2])
					+ 67'(HALF_Q30);
				hi_s11[j]  <= HSW'(phi_s10[j][0]) + HSW'(phi_s10[j][1]) + HSW'(phi_s10[j][2]);
				r_s12[j]   <= RW'(tot_d[j] >>> UNIT_FRAC);
				rot_s13[j] <= rot_d[j];
			end
			zero_s6 <= div_s[QUO_BITS].zero;
			c_s6    <= c_d;
			s_s6    <= s_d;
			t_s6    <= XW'(ONE_Q30) - c_d;
			zero_s7 <= zero_s6;
			c_s7    <= c_s6;
			zero_s8 <= zero_s7;
			c_s8    <= c_s7;
			txx_s8  <= mulq(tx_s7[0], u_s7[0]);
			tyy_s8  <= mulq(tx_s7[1], u_s7[1]);
			tzz_s8  <= mulq(tx_s7[2], u_s7[2]);
			txy_s8  <= mulq(tx_s7[0], u_s7[1]);
			txz_s8  <= mulq(tx_s7[0], u_s7[2]);
			tyz_s8  <= mulq(tx_s7[1], u_s7[2]);
			zero_s9 <= zero_s8;
			m_s9[0][0] <= clamp_unit((XW + 1)'(c_s8) + (XW + 1)'(txx_s8));
			m_s9[0][1] <= clamp_unit((XW + 1)'(txy_s8) - (XW + 1)'(sx_s8[2]));
			m_s9[0][2] <= clamp_unit((XW + 1)'(txz_s8) + (XW + 1)'(sx_s8[1]));
			m_s9[1][0] <= clamp_unit((XW + 1)'(txy_s8) + (XW + 1)'(sx_s8[2]));
			m_s9[1][1] <= clamp_unit((XW + 1)'(c_s8) + (XW + 1)'(tyy_s8));
			m_s9[1][2] <= clamp_unit((XW + 1)'(tyz_s8) - (XW + 1)'(sx_s8[0]));
			m_s9[2][0] <= clamp_unit((XW + 1)'(txz_s8) - (XW + 1)'(sx_s8[1]));
			m_s9[2][1] <= clamp_unit((XW + 1)'(tyz_s8) + (XW + 1)'(sx_s8[0]));
			m_s9[2][2] <= clamp_unit((XW + 1)'(c_s8) + (XW + 1)'(tzz_s8));
			zero_s10 <= zero_s9;
			zero_s11 <= zero_s10;
			zero_s12 <= zero_s11;
			zero_s13 <= zero_s12;
			sat_s13  <= |ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= point_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= div_v[QUO_BITS];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	assign rotated_valid  = v_s13;
	assign rotated_x      = rot_s13[0];
	assign rotated_y      = rot_s13[1];
	assign rotated_z      = rot_s13[2];
	assign saturated_flag = sat_s13;
	assign zero_axis_flag = zero_s13;

	// an accepted word lands in the first stage
	`AAPR_ASSERT_NEXT(a_accept_enters, point_valid && !point_stall, v_s1)
	// unit components never exceed one
	`AAPR_ASSERT_NOW(a_quo_bound, div_v[QUO_BITS] && !div_s[QUO_BITS].zero,
		(div_s[QUO_BITS].quo[0] <= QUO_MAX) && (div_s[QUO_BITS].quo[1] <= QUO_MAX)
		&& (div_s[QUO_BITS].quo[2] <= QUO_MAX))
	// a zero axis leaves the unit vector zero
	`AAPR_ASSERT_NOW(a_zero_axis, v_s6 && zero_s6,
		(u_s6[0] == '0) && (u_s6[1] == '0) && (u_s6[2] == '0))

endmodule

`default_nettype wire
